// File: rtl/core/sccpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sccpa_pkg
// Widths, fixed-point constants and rounding terms shared by the parabolic
// sine/cosine approximation core and its angle reduction stage.
// ----------------------------------------------------------------------------
package sccpa_pkg;

  // Port widths.
  localparam int ANG_W = 18;  // angle, signed Q5.13
  localparam int VAL_W = 16;  // result, signed Q2.14

  // Angle reduction works one bit wider than the port so adds cannot overflow.
  localparam int WRAP_W = ANG_W + 1;

  localparam logic signed [WRAP_W-1:0] ANG_PI      = WRAP_W'(25736);
  localparam logic signed [WRAP_W-1:0] ANG_TWO_PI  = WRAP_W'(51472);
  localparam logic signed [WRAP_W-1:0] ANG_HALF_PI = WRAP_W'(12868);

  // Coefficients in Q16: 4/pi, 4/pi^2 and the refinement weight 0.225.
  localparam int COEF_B_W = 18;
  localparam int COEF_C_W = 16;
  localparam int COEF_P_W = 15;
  localparam logic signed [COEF_B_W-1:0] COEF_B = COEF_B_W'(83443);
  localparam logic signed [COEF_C_W-1:0] COEF_C = COEF_C_W'(26561);
  localparam logic signed [COEF_P_W-1:0] COEF_P = COEF_P_W'(14746);

  // Datapath widths. The reduced angle stays within +/-79600, so it fits
  // in ANG_W bits, and the parabola output stays within about +/-425000.
  localparam int X_W     = ANG_W;
  localparam int BX_W    = X_W + COEF_B_W;
  localparam int XX_W    = 2 * X_W;
  localparam int ACC_W   = XX_W + COEF_C_W;
  localparam int Y_W     = 21;
  localparam int YY_W    = 2 * Y_W;
  localparam int D_W     = YY_W + 1;
  localparam int DLO_W   = 21;
  localparam int DHI_W   = D_W - DLO_W;
  localparam int PP_W    = COEF_P_W + DHI_W;
  localparam int R_W     = 60;

  // Shift amounts of the two rounding steps and of the Q-format alignments.
  localparam int BX_SHIFT = 13;
  localparam int Y_SHIFT  = 28;
  localparam int YQ_SHIFT = 14;
  localparam int R_SHIFT  = 30;
  localparam int Q_W      = R_W - R_SHIFT;

  localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'(64'd1 << (Y_SHIFT - 1));
  localparam logic signed [R_W-1:0]   R_RND   = R_W'(64'd1 << (R_SHIFT - 1));

  localparam logic signed [Q_W-1:0] VAL_MAX = Q_W'((64'd1 << (VAL_W - 1)) - 64'd1);
  localparam logic signed [Q_W-1:0] VAL_MIN = -Q_W'(64'd1 << (VAL_W - 1));

  // Function select codes.
  localparam logic OP_SINE   = 1'b0;
  localparam logic OP_COSINE = 1'b1;

  // Number of register stages from input to output.
  localparam int NSTG = 8;

endpackage

// File: rtl/core/sccpa_wrap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sccpa_wrap
// Angle reduction: one wrap by 2*pi toward -pi..pi, then for cosine a
// quarter-turn shift and one more wrap from above.
// ----------------------------------------------------------------------------
module sccpa_wrap (
  input  logic                               op,
  input  logic signed [sccpa_pkg::ANG_W-1:0] angle,
  output logic signed [sccpa_pkg::X_W-1:0]   x
);

  logic signed [sccpa_pkg::WRAP_W-1:0] a0;
  logic signed [sccpa_pkg::WRAP_W-1:0] a1;
  logic signed [sccpa_pkg::WRAP_W-1:0] a2;
  logic signed [sccpa_pkg::WRAP_W-1:0] a3;

  always_comb begin
    a0 = sccpa_pkg::WRAP_W'(angle);
    if (a0 < -sccpa_pkg::ANG_PI) begin
      a1 = a0 + sccpa_pkg::ANG_TWO_PI;
    end else if (a0 > sccpa_pkg::ANG_PI) begin
      a1 = a0 - sccpa_pkg::ANG_TWO_PI;
    end else begin
      a1 = a0;
    end

    a2 = a1 + sccpa_pkg::ANG_HALF_PI;
    if (op == sccpa_pkg::OP_COSINE) begin
      a3 = (a2 > sccpa_pkg::ANG_PI) ? (a2 - sccpa_pkg::ANG_TWO_PI) : a2;
    end else begin
      a3 = a1;
    end

    // Angles beyond three half-turns are not folded further, but every
    // reachable value still fits in the port width.
    x = a3[sccpa_pkg::X_W-1:0];
  end

endmodule

// File: rtl/core/sine_cosine_parabolic_approx_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_cosine_parabolic_approx_core
// Parabolic sine/cosine approximation with one refinement step. Q5.13 angle
// in, rounded and saturated Q2.14 value out.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                          Direction   Meaning
//  input     in_valid in_stall in_op        in (stall   op: 0 sine, 1 cosine
//            in_angle                        is out)    angle: signed Q5.13
//  result    out_valid out_stall out_value  out (stall  value: signed Q2.14
//                                            is in)
//
//  One transfer per clock is accepted unless a full pipeline meets an
//  output stall; the 8 register stages are wrap, two multiply stages,
//  round, square, subtract, split multiply, final add and saturate.
//  Each stage holds its own valid bit and loads when it is empty or when the
//  stage after it moves, so bubbles close up under a stall and nothing is
//  lost or repeated.
//  Reset clears the valid bits only; the pipeline is ready right after it.
//
module sine_cosine_parabolic_approx_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_op,
  input  logic signed [sccpa_pkg::ANG_W-1:0] in_angle,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [sccpa_pkg::VAL_W-1:0] out_value
);

  localparam int NSTG = sccpa_pkg::NSTG;

  logic [NSTG:1]   vld_r;
  logic [NSTG-1:0] vin;
  logic [NSTG:1]   rdy;
  logic [NSTG:1]   vld_nxt;

  // Stage payloads.
  logic signed [sccpa_pkg::X_W-1:0]   x1_r, x1_nxt;
  logic signed [sccpa_pkg::BX_W-1:0]  bx2_r, bx2_nxt;
  logic signed [sccpa_pkg::XX_W-1:0]  xx2_r, xx2_nxt;
  logic signed [sccpa_pkg::BX_W-1:0]  bx3_r;
  logic signed [sccpa_pkg::ACC_W-1:0] cxx3_r, cxx3_nxt;
  logic signed [sccpa_pkg::Y_W-1:0]   y4_r, y4_nxt;
  logic signed [sccpa_pkg::YY_W-1:0]  yy5_r, yy5_nxt;
  logic signed [sccpa_pkg::Y_W-1:0]   y5_r;
  logic signed [sccpa_pkg::D_W-1:0]   d6_r, d6_nxt;
  logic signed [sccpa_pkg::Y_W-1:0]   y6_r;
  logic signed [sccpa_pkg::PP_W-1:0]  pl7_r, pl7_nxt;
  logic signed [sccpa_pkg::PP_W-1:0]  ph7_r, ph7_nxt;
  logic signed [sccpa_pkg::Y_W-1:0]   y7_r;
  logic signed [sccpa_pkg::VAL_W-1:0] out_value_r, out_value_nxt;

  // Combinational helpers.
  logic signed [sccpa_pkg::X_W-1:0]   x_wrap;
  logic signed [sccpa_pkg::X_W-1:0]   x1_abs;
  logic signed [sccpa_pkg::ACC_W-1:0] acc;
  logic signed [sccpa_pkg::ACC_W-1:0] acc_rnd;
  logic signed [sccpa_pkg::Y_W-1:0]   y4_abs;
  logic signed [sccpa_pkg::DHI_W-1:0] d_hi;
  logic signed [sccpa_pkg::DLO_W:0]   d_lo;
  logic signed [sccpa_pkg::R_W-1:0]   r_sum;
  logic signed [sccpa_pkg::Q_W-1:0]   q;

  sccpa_wrap u_wrap (
    .op    (in_op),
    .angle (in_angle),
    .x     (x_wrap)
  );

  // Handshake: a stage may load when it is empty or its successor loads.
  always_comb begin
    vin[0]        = in_valid;
    vin[NSTG-1:1] = vld_r[NSTG-1:1];
    rdy[NSTG]  = !vld_r[NSTG] || !out_stall;
    for (int k = NSTG - 1; k >= 1; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    for (int k = 1; k <= NSTG; k++) begin
      vld_nxt[k] = rdy[k] ? vin[k-1] : vld_r[k];
    end
  end

  assign in_stall  = !rdy[1];
  assign out_valid = vld_r[NSTG];
  assign out_value = out_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Datapath.
  always_comb begin
    x1_nxt   = x_wrap;

    x1_abs   = x1_r[sccpa_pkg::X_W-1] ? -x1_r : x1_r;
    bx2_nxt  = x1_r * sccpa_pkg::COEF_B;
    xx2_nxt  = x1_r * x1_abs;

    cxx3_nxt = xx2_r * sccpa_pkg::COEF_C;

    // Parabola in Q42, rounded half up to Q14.
    acc      = (sccpa_pkg::ACC_W'(bx3_r) <<< sccpa_pkg::BX_SHIFT) - cxx3_r;
    acc_rnd  = (acc + sccpa_pkg::ACC_RND) >>> sccpa_pkg::Y_SHIFT;
    y4_nxt   = acc_rnd[sccpa_pkg::Y_W-1:0];

    y4_abs   = y4_r[sccpa_pkg::Y_W-1] ? -y4_r : y4_r;
    yy5_nxt  = y4_r * y4_abs;

    d6_nxt   = sccpa_pkg::D_W'(yy5_r) - (sccpa_pkg::D_W'(y5_r) <<< sccpa_pkg::YQ_SHIFT);

    // The weight times the difference is split into two narrow products.
    d_hi     = d6_r[sccpa_pkg::D_W-1:sccpa_pkg::DLO_W];
    d_lo     = {1'b0, d6_r[sccpa_pkg::DLO_W-1:0]};
    ph7_nxt  = d_hi * sccpa_pkg::COEF_P;
    pl7_nxt  = d_lo * sccpa_pkg::COEF_P;

    r_sum    = (sccpa_pkg::R_W'(y7_r) <<< sccpa_pkg::R_SHIFT)
             + (sccpa_pkg::R_W'(ph7_r) <<< sccpa_pkg::DLO_W)
             + sccpa_pkg::R_W'(pl7_r)
             + sccpa_pkg::R_RND;
    q        = r_sum[sccpa_pkg::R_W-1:sccpa_pkg::R_SHIFT];
    if (q > sccpa_pkg::VAL_MAX) begin
      out_value_nxt = sccpa_pkg::VAL_MAX[sccpa_pkg::VAL_W-1:0];
    end else if (q < sccpa_pkg::VAL_MIN) begin
      out_value_nxt = sccpa_pkg::VAL_MIN[sccpa_pkg::VAL_W-1:0];
    end else begin
      out_value_nxt = q[sccpa_pkg::VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1] && vin[0]) begin
      x1_r <= x1_nxt;
    end
    if (rdy[2] && vin[1]) begin
      bx2_r <= bx2_nxt;
      xx2_r <= xx2_nxt;
    end
    if (rdy[3] && vin[2]) begin
      bx3_r  <= bx2_r;
      cxx3_r <= cxx3_nxt;
    end
    if (rdy[4] && vin[3]) begin
      y4_r <= y4_nxt;
    end
    if (rdy[5] && vin[4]) begin
      yy5_r <= yy5_nxt;
      y5_r  <= y4_r;
    end
    if (rdy[6] && vin[5]) begin
      d6_r <= d6_nxt;
      y6_r <= y5_r;
    end
    if (rdy[7] && vin[6]) begin
      pl7_r <= pl7_nxt;
      ph7_r <= ph7_nxt;
      y7_r  <= y6_r;
    end
    if (rdy[8] && vin[7]) begin
      out_value_r <= out_value_nxt;
    end
  end

  // A full pipeline with a stalled output must hold off the input.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    ((&vld_r) && out_stall) |-> in_stall)
    else $error("input accepted while every stage is full and stalled");

  // An empty first stage always takes a transfer.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[1] |-> !in_stall)
    else $error("input stalled with an empty first stage");

  // An accepted transfer occupies the first stage on the next cycle.
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[1])
    else $error("accepted transfer did not enter the pipeline");

  // A zero parabola value refines to a zero result.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[7] && rdy[8] && (y7_r == '0)) |=> (out_value_r == '0))
    else $error("zero parabola did not give a zero result");

endmodule

// File: sim/tb_sine_cosine_parabolic_approx_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sine_cosine_parabolic_approx_core
// Self-checking bench for the parabolic sine/cosine core. A queue of angle
// requests feeds a driver that idles in random bursts. A monitor computes
// the expected Q2.14 value of every accepted request and checks the results
// in order while the result side stalls at random.
// ----------------------------------------------------------------------------
module tb_sine_cosine_parabolic_approx_core;

  // Fixed-point constants of the approximation, angles in Q13, weights in Q16.
  localparam longint PI_Q13      = 25736;
  localparam longint TWO_PI_Q13  = 51472;
  localparam longint HALF_PI_Q13 = 12868;
  localparam longint THREE_PI_Q13 = 77208;
  localparam longint WEIGHT_B    = 83443;
  localparam longint WEIGHT_C    = 26561;
  localparam longint WEIGHT_P    = 14746;

  typedef struct packed {
    logic                               op;
    logic signed [sccpa_pkg::ANG_W-1:0] angle;
  } angle_req_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic                               in_op = 1'b0;
  logic signed [sccpa_pkg::ANG_W-1:0] in_angle = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic signed [sccpa_pkg::VAL_W-1:0] out_value;

  angle_req_t                         pending_q[$];
  logic signed [sccpa_pkg::VAL_W-1:0] value_q[$];

  int unsigned mismatch_count = 0;
  bit          in_taken = 1'b0;
  bit          calm = 1'b0;
  int unsigned gap_left = 0;
  int unsigned gap_quiet = 0;
  int unsigned stall_left = 0;
  int unsigned stall_quiet = 0;

  sine_cosine_parabolic_approx_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_op     (in_op),
    .in_angle  (in_angle),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_value (out_value)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Wrap once by 2*pi, shift by pi/2 for cosine, form the parabola, refine
  // it and saturate to Q2.14. Every rounding adds half an LSB and floors.
  function automatic logic signed [sccpa_pkg::VAL_W-1:0] sincos_value(
      logic op, logic signed [sccpa_pkg::ANG_W-1:0] angle);
    longint a;
    longint mag_a;
    longint acc;
    longint y;
    longint mag_y;
    longint d;
    longint r;
    a = angle;
    if (a < -PI_Q13) begin
      a = a + TWO_PI_Q13;
    end else if (a > PI_Q13) begin
      a = a - TWO_PI_Q13;
    end
    if (op == sccpa_pkg::OP_COSINE) begin
      a = a + HALF_PI_Q13;
      if (a > PI_Q13) begin
        a = a - TWO_PI_Q13;
      end
    end
    mag_a = (a < 0) ? -a : a;
    acc = WEIGHT_B * a * 64'sd8192 - WEIGHT_C * a * mag_a;
    y = (acc + (64'sd1 <<< 27)) >>> 28;
    mag_y = (y < 0) ? -y : y;
    d = y * mag_y - y * 64'sd16384;
    r = y * (64'sd1 <<< 30) + WEIGHT_P * d;
    r = (r + (64'sd1 <<< 29)) >>> 30;
    if (r > 32767) begin
      r = 32767;
    end else if (r < -32768) begin
      r = -32768;
    end
    return r[sccpa_pkg::VAL_W-1:0];
  endfunction

  task automatic push_req(logic op, int angle);
    angle_req_t req;
    req.op = op;
    req.angle = angle[sccpa_pkg::ANG_W-1:0];
    pending_q.push_back(req);
  endtask

  // Mostly angles in -pi..pi, some over the whole port range, and some close
  // to the wrap and clip boundaries.
  task automatic push_random_req();
    int angle;
    int base;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      angle = int'($urandom_range(0, 2 * PI_Q13)) - int'(PI_Q13);
    end else if (pick < 8) begin
      angle = int'($urandom_range(0, 262143)) - 131072;
    end else begin
      case ($urandom_range(0, 5))
        0: base = int'(PI_Q13);
        1: base = -int'(PI_Q13);
        2: base = int'(THREE_PI_Q13);
        3: base = -int'(THREE_PI_Q13);
        4: base = int'(HALF_PI_Q13);
        default: base = -int'(HALF_PI_Q13);
      endcase
      angle = base + int'($urandom_range(0, 6)) - 3;
    end
    push_req(1'($urandom_range(0, 1)), angle);
  endtask

  task automatic report_mismatch(string what, logic signed [sccpa_pkg::VAL_W-1:0] exp_v,
                                 logic signed [sccpa_pkg::VAL_W-1:0] act_v);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s: expected value %0d, got %0d", $realtime, what, exp_v, act_v);
    end
  endtask

  // Driver: a stalled transfer keeps its payload; new requests are held back
  // by random idle bursts.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      in_valid <= 1'b1;
    end else if (gap_left != 0) begin
      gap_left--;
      in_valid <= 1'b0;
      in_op    <= 1'($urandom_range(0, 1));
      in_angle <= sccpa_pkg::ANG_W'($urandom);
    end else if (pending_q.size() != 0 && !calm && gap_quiet == 0 &&
                 $urandom_range(0, 7) == 0) begin
      gap_left  = $urandom_range(0, 13);
      gap_quiet = $urandom_range(0, 40);
      in_valid <= 1'b0;
      in_op    <= 1'($urandom_range(0, 1));
      in_angle <= sccpa_pkg::ANG_W'($urandom);
    end else if (pending_q.size() != 0) begin
      if (gap_quiet != 0) begin
        gap_quiet--;
      end
      in_valid <= 1'b1;
      in_op    <= pending_q[0].op;
      in_angle <= pending_q[0].angle;
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (rst_n && !calm && stall_quiet == 0 && $urandom_range(0, 9) == 0) begin
      stall_left  = $urandom_range(0, 13);
      stall_quiet = $urandom_range(0, 40);
      out_stall <= 1'b1;
    end else begin
      if (stall_quiet != 0) begin
        stall_quiet--;
      end
      out_stall <= 1'b0;
    end
  end

  // Monitor: every accepted request adds its expected value, every accepted
  // result is checked against the oldest one.
  always @(posedge clk) begin
    angle_req_t                         req;
    logic signed [sccpa_pkg::VAL_W-1:0] exp_v;
    if (rst_n) begin
      in_taken = in_valid && !in_stall;
      if (in_taken) begin
        req = pending_q.pop_front();
        value_q.push_back(sincos_value(req.op, req.angle));
      end
      if (out_valid && !out_stall) begin
        if (value_q.size() == 0) begin
          report_mismatch("result with nothing outstanding", '0, out_value);
        end else begin
          exp_v = value_q.pop_front();
          if (out_value !== exp_v) begin
            report_mismatch("value mismatch", exp_v, out_value);
          end
        end
      end
    end
  end

  task automatic wait_sent();
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic wait_drained();
    wait_sent();
    while (value_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    int angles[12];
    angles = '{-131072, 131071, 0, 25736, -25736, 25737, -25737,
               77208, 77209, -77209, 12868, 12869};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Port extremes, the pi boundaries, the edge of the single wrap and the
    // point where the cosine shift wraps again, for both functions.
    foreach (angles[i]) begin
      push_req(sccpa_pkg::OP_SINE, angles[i]);
      push_req(sccpa_pkg::OP_COSINE, angles[i]);
    end
    wait_drained();

    repeat (700) push_random_req();
    // The sender holds off here until every result is back.
    wait_drained();
    repeat (600) push_random_req();
    wait_sent();
    calm = 1'b1;
    repeat (150) push_random_req();
    wait_drained();
    repeat (4 * sccpa_pkg::NSTG) @(posedge clk);

    if (mismatch_count == 0 && value_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
